// File: hw/rtl/bta_pkg.sv
`default_nettype none

package bta_pkg;

   // Default heap geometry
   localparam int HEAP_UNITS_DEF   = 4096;
   localparam int HEADER_UNITS_DEF = 1;

   // Field widths of the request and response channels
   localparam int SIZE_W = 12;
   localparam int OFF_W  = 12;
   localparam int OP_W   = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_RESIZE = 2'd2;

   // Status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BK_RD,
      ST_BK_CHK,
      ST_FR_RD,
      ST_FR_A,
      ST_FR_NRD,
      ST_FR_N,
      ST_FR_P,
      ST_FR_PRD,
      ST_FR_PC,
      ST_FR_W,
      ST_RZ_A,
      ST_RZ_NRD,
      ST_RZ_N,
      ST_RZ_S,
      ST_RZ_T,
      ST_RZ_HW,
      ST_RZ_G,
      ST_AL_INIT,
      ST_AL_RD,
      ST_AL_CHK,
      ST_AL_P1,
      ST_AL_P2,
      ST_AL_WH,
      ST_AL_WP,
      ST_AL_WR,
      ST_AL_DONE,
      ST_LK_RD,
      ST_LK_WR,
      ST_RC_INIT,
      ST_RC_RD,
      ST_RC_CHK,
      ST_DONE
   } bta_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/bta_req_if.sv
`default_nettype none

interface bta_req_if
   import bta_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [SIZE_W-1:0] req_size;
   logic [OFF_W-1:0]  block_offset;

   modport source (output valid, output op, output req_size, output block_offset,
                   input ready);
   modport sink   (input valid, input op, input req_size, input block_offset,
                   output ready);
endinterface

interface bta_rsp_if
   import bta_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              status;
   logic [OFF_W-1:0]  result_offset;
   logic              moved;
   logic [SIZE_W-1:0] largest_free;

   modport source (output valid, output status, output result_offset, output moved,
                   output largest_free, input ready);
   modport sink   (input valid, input status, input result_offset, input moved,
                   input largest_free, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bta_ram.sv
`default_nettype none

module bta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/boundary_tag_heap_allocator.sv
`default_nettype none

// Channel   Dir  Payload                                        Accepted when
// req_chan  in   op, req_size, block_offset                     valid && ready
// rsp_chan  out  status, result_offset, moved, largest_free     valid && ready
// csr       in   csr_wdata (split_half_mode)                    csr_we
//
// One request at a time. Every header access goes through the single port pair
// of the header RAM, whose read is registered; a request walks its B blocks
// twice when it allocates (first fit, then the largest-free rescan) and once
// otherwise (the rescan), besides the control and header updates.
// After reset a clearing pass over all HEAP_UNITS header words runs with ready low.
// A finished response waits in the output register; the next request is taken
// meanwhile, but its response is held until the first one is taken.

module boundary_tag_heap_allocator
   import bta_pkg::*;
#(
   parameter int HEAP_UNITS   = HEAP_UNITS_DEF,
   parameter int HEADER_UNITS = HEADER_UNITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bta_req_if.sink     req_chan,
   bta_rsp_if.source   rsp_chan,
   input  wire logic   csr_we,
   input  wire logic   csr_wdata
);

   localparam int AW = $clog2(HEAP_UNITS);
   localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;
   localparam logic [CW-1:0] HEAP_C = CW'(HEAP_UNITS);
   localparam logic [CW-1:0] HDR_C  = CW'(HEADER_UNITS);
   localparam logic [CW-1:0] LF_MAX = CW'(4095);

   typedef struct packed {
      logic          start;
      logic          used;
      logic          has_prev;
      logic [AW-1:0] size;
      logic [AW-1:0] prev;
   } hdr_type;

   localparam int HW = $bits(hdr_type);

   // Control
   bta_state_type state_ff, state_in;
   logic [AW-1:0] clr_ff;
   logic          mode_ff;
   logic          rsp_valid_ff;

   // Request and working registers
   logic [OP_W-1:0] op_ff;
   logic [CW-1:0]   req_ff;
   logic [AW-1:0]   hb_ff;
   hdr_type         hw_ff;
   hdr_type         aw_ff;
   logic [AW-1:0]   fb_ff;
   logic [CW-1:0]   w_ff;
   logic [CW-1:0]   nxt_ff;
   logic [CW-1:0]   nn_ff;
   logic [CW-1:0]   tot_ff;
   logic [AW-1:0]   tail_ff;
   logic [AW-1:0]   page_ff;
   logic [CW-1:0]   rem_ff;
   logic [AW-1:0]   r_ff;
   logic [AW-1:0]   rsz_ff;
   logic [AW-1:0]   pgsize_ff;
   logic            split_ff;
   logic            half_ff;
   logic            mkr_ff;
   logic [CW-1:0]   lk_addr_ff;
   logic [AW-1:0]   lk_val_ff;
   bta_state_type   lk_ret_ff;
   logic [AW-1:0]   best_ff;
   logic            st_ff;
   logic [CW-1:0]   res_ff;
   logic            mv_ff;

   // Response register
   logic              rsp_status_ff;
   logic [OFF_W-1:0]  rsp_res_ff;
   logic              rsp_moved_ff;
   logic [SIZE_W-1:0] rsp_lf_ff;

   // RAM ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   hdr_type       ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [HW-1:0] ram_rdata;
   hdr_type       rd_word;

   // Shared datapath terms
   logic          req_fire;
   logic          rsp_free;
   logic [CW-1:0] off_c;
   logic          bad_off;
   logic [CW-1:0] rd_sz;
   logic [CW-1:0] walk_next;
   logic [CW-1:0] hb_next;
   logic          fit;
   logic [CW-1:0] rz_total;
   logic          rz_absorb;
   logic [CW-1:0] a_sz;
   logic          a_split;
   logic          a_half;
   logic [CW-1:0] pg_c;

   bta_ram #(
      .WIDTH (HW),
      .DEPTH (HEAP_UNITS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_word  = hdr_type'(ram_rdata);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // Shared arithmetic terms
   always_comb begin
      off_c     = CW'(req_chan.block_offset);
      bad_off   = (off_c < HDR_C) || ((off_c - HDR_C) >= HEAP_C);
      rd_sz     = CW'(rd_word.size);
      walk_next = w_ff + HDR_C + rd_sz;
      hb_next   = CW'(hb_ff) + HDR_C + CW'(hw_ff.size);
      fit       = !rd_word.used && (rd_sz >= req_ff);
      rz_total  = CW'(hw_ff.size) + HDR_C + rd_sz;
      rz_absorb = !rd_word.used && (rz_total > req_ff);
      a_sz      = CW'(aw_ff.size);
      a_split   = (a_sz - req_ff) > HDR_C;
      a_half    = a_split && mode_ff && ((a_sz >> 1) > (HDR_C + req_ff));
      pg_c      = (rem_ff > HDR_C) ? req_ff : (req_ff + rem_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clr_ff == AW'(HEAP_UNITS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.op)
                  OP_ALLOC:           state_in = ST_AL_INIT;
                  OP_FREE, OP_RESIZE: state_in = bad_off ? ST_RC_INIT : ST_BK_RD;
                  default:            state_in = ST_RC_INIT;
               endcase
            end
         end
         ST_BK_RD:   state_in = ST_BK_CHK;
         ST_BK_CHK: begin
            if (!(rd_word.start && rd_word.used)) state_in = ST_RC_INIT;
            else if (op_ff == OP_FREE)            state_in = ST_FR_RD;
            else                                  state_in = ST_RZ_A;
         end
         ST_FR_RD:   state_in = ST_FR_A;
         ST_FR_A: begin
            if ((CW'(hb_ff) + HDR_C + rd_sz) < HEAP_C) state_in = ST_FR_NRD;
            else                                      state_in = ST_FR_P;
         end
         ST_FR_NRD:  state_in = ST_FR_N;
         ST_FR_N:    state_in = rd_word.used ? ST_FR_P : ST_LK_RD;
         ST_FR_P: begin
            if (hw_ff.has_prev && (CW'(hw_ff.prev) < HEAP_C)) state_in = ST_FR_PRD;
            else                                             state_in = ST_FR_W;
         end
         ST_FR_PRD:  state_in = ST_FR_PC;
         ST_FR_PC:   state_in = rd_word.used ? ST_FR_W : ST_LK_RD;
         ST_FR_W:    state_in = ST_RC_INIT;
         ST_RZ_A:    state_in = (hb_next < HEAP_C) ? ST_RZ_NRD : ST_RZ_G;
         ST_RZ_NRD:  state_in = ST_RZ_N;
         ST_RZ_N:    state_in = rz_absorb ? ST_RZ_S : ST_RZ_G;
         ST_RZ_S:    state_in = ((tot_ff - req_ff) > HDR_C) ? ST_RZ_T : ST_RZ_HW;
         ST_RZ_T:    state_in = ST_RZ_HW;
         ST_RZ_HW:   state_in = ST_LK_RD;
         ST_RZ_G:    state_in = (req_ff > CW'(hw_ff.size)) ? ST_AL_INIT : ST_RC_INIT;
         ST_AL_INIT: state_in = ST_AL_RD;
         ST_AL_RD:   state_in = (w_ff >= HEAP_C) ? ST_RC_INIT : ST_AL_CHK;
         ST_AL_CHK:  state_in = fit ? ST_AL_P1 : ST_AL_RD;
         ST_AL_P1:   state_in = ST_AL_P2;
         ST_AL_P2:   state_in = ST_AL_WH;
         ST_AL_WH:   state_in = ST_AL_WP;
         ST_AL_WP:   state_in = ST_AL_WR;
         ST_AL_WR:   state_in = split_ff ? ST_LK_RD : ST_AL_DONE;
         ST_AL_DONE: state_in = (op_ff == OP_RESIZE) ? ST_FR_RD : ST_RC_INIT;
         ST_LK_RD:   state_in = (lk_addr_ff < HEAP_C) ? ST_LK_WR : lk_ret_ff;
         ST_LK_WR:   state_in = lk_ret_ff;
         ST_RC_INIT: state_in = ST_RC_RD;
         ST_RC_RD:   state_in = (w_ff >= HEAP_C) ? ST_DONE : ST_RC_CHK;
         ST_RC_CHK:  state_in = ST_RC_RD;
         ST_DONE:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // RAM control per state
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = hb_ff;
      ram_wdata = rd_word;
      ram_re    = 1'b0;
      ram_raddr = hb_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == '0) begin
               ram_wdata.start = 1'b1;
               ram_wdata.size  = AW'(HEAP_UNITS - HEADER_UNITS);
            end
         end
         ST_IDLE:   ram_raddr = AW'(off_c - HDR_C);
         ST_BK_RD, ST_FR_RD: ram_re = 1'b1;
         ST_FR_NRD, ST_RZ_NRD: begin
            ram_re    = 1'b1;
            ram_raddr = nxt_ff[AW-1:0];
         end
         ST_FR_N, ST_RZ_N: begin
            // absorbed neighbour loses its header
            ram_we          = (state_ff == ST_FR_N) ? !rd_word.used : rz_absorb;
            ram_waddr       = nxt_ff[AW-1:0];
            ram_wdata.start = 1'b0;
         end
         ST_FR_PRD: begin
            ram_re    = 1'b1;
            ram_raddr = hw_ff.prev;
         end
         ST_FR_PC: begin
            ram_we         = !rd_word.used;
            ram_waddr      = hw_ff.prev;
            ram_wdata.size = AW'(rd_sz + HDR_C + CW'(hw_ff.size));
         end
         ST_FR_W, ST_RZ_HW: begin
            ram_we    = 1'b1;
            ram_wdata = hw_ff;
         end
         ST_RZ_T: begin
            ram_we    = 1'b1;
            ram_waddr = tail_ff;
            ram_wdata = '{start: 1'b1, used: 1'b0, has_prev: 1'b1,
                          size: AW'(tot_ff - req_ff - HDR_C), prev: hb_ff};
         end
         ST_AL_RD, ST_RC_RD: begin
            ram_re    = (w_ff < HEAP_C);
            ram_raddr = w_ff[AW-1:0];
         end
         ST_AL_WH: begin
            ram_we    = 1'b1;
            ram_waddr = fb_ff;
            ram_wdata = aw_ff;
         end
         ST_AL_WP: begin
            ram_we    = half_ff;
            ram_waddr = page_ff;
            ram_wdata = '{start: 1'b1, used: 1'b1, has_prev: 1'b1,
                          size: pgsize_ff, prev: fb_ff};
         end
         ST_AL_WR: begin
            ram_we    = mkr_ff;
            ram_waddr = r_ff;
            ram_wdata = '{start: 1'b1, used: 1'b0, has_prev: 1'b1,
                          size: rsz_ff, prev: page_ff};
         end
         ST_LK_RD: begin
            ram_re    = (lk_addr_ff < HEAP_C);
            ram_raddr = lk_addr_ff[AW-1:0];
         end
         ST_LK_WR: begin
            ram_we             = 1'b1;
            ram_waddr          = lk_addr_ff[AW-1:0];
            ram_wdata.prev     = lk_val_ff;
            ram_wdata.has_prev = 1'b1;
         end
         default: ram_we = 1'b0;
      endcase
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.result_offset = rsp_res_ff;
   assign rsp_chan.moved         = rsp_moved_ff;
   assign rsp_chan.largest_free  = rsp_lf_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (csr_we) mode_ff <= csr_wdata;
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)             rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            op_ff  <= req_chan.op;
            req_ff <= CW'(req_chan.req_size);
            hb_ff  <= AW'(off_c - HDR_C);
            st_ff  <= STATUS_FAIL;
            res_ff <= '0;
            mv_ff  <= 1'b0;
         end
         ST_BK_CHK: begin
            hw_ff <= rd_word;
            if (rd_word.start && rd_word.used) begin
               st_ff <= STATUS_OK;
               if (op_ff == OP_RESIZE) res_ff <= CW'(hb_ff) + HDR_C;
            end
         end
         ST_FR_A: begin
            hw_ff  <= '{start: rd_word.start, used: 1'b0, has_prev: rd_word.has_prev,
                        size: rd_word.size, prev: rd_word.prev};
            nxt_ff <= CW'(hb_ff) + HDR_C + rd_sz;
         end
         ST_FR_N: begin
            // merge with the free block above
            if (!rd_word.used) begin
               hw_ff.size <= AW'(CW'(hw_ff.size) + HDR_C + rd_sz);
               lk_addr_ff <= nxt_ff + HDR_C + rd_sz;
               lk_val_ff  <= hb_ff;
               lk_ret_ff  <= ST_FR_P;
            end
         end
         ST_FR_PC: begin
            // merge into the free block below
            if (!rd_word.used) begin
               hw_ff.start <= 1'b0;
               lk_addr_ff  <= hb_next;
               lk_val_ff   <= hw_ff.prev;
               lk_ret_ff   <= ST_FR_W;
            end
         end
         ST_RZ_A:    nxt_ff <= hb_next;
         ST_RZ_N: begin
            tot_ff <= rz_total;
            nn_ff  <= nxt_ff + HDR_C + rd_sz;
         end
         ST_RZ_S: begin
            if ((tot_ff - req_ff) > HDR_C) begin
               hw_ff.size <= AW'(req_ff);
               tail_ff    <= AW'(CW'(hb_ff) + HDR_C + req_ff);
            end else begin
               hw_ff.size <= AW'(tot_ff);
               tail_ff    <= hb_ff;
            end
         end
         ST_RZ_HW: begin
            lk_addr_ff <= nn_ff;
            lk_val_ff  <= tail_ff;
            lk_ret_ff  <= ST_RC_INIT;
         end
         ST_AL_INIT: w_ff <= '0;
         ST_AL_RD: begin
            if (w_ff >= HEAP_C) begin
               st_ff  <= STATUS_FAIL;
               res_ff <= '0;
            end
         end
         ST_AL_CHK: begin
            if (fit) begin
               aw_ff <= rd_word;
               fb_ff <= w_ff[AW-1:0];
            end else begin
               w_ff <= walk_next;
            end
         end
         ST_AL_P1: begin
            nxt_ff   <= CW'(fb_ff) + HDR_C + a_sz;
            split_ff <= a_split;
            half_ff  <= a_half;
            if (a_half) begin
               rem_ff     <= a_sz - (a_sz >> 1) - HDR_C - req_ff;
               page_ff    <= AW'(CW'(fb_ff) + HDR_C + (a_sz >> 1));
               aw_ff.size <= AW'(a_sz >> 1);
            end else begin
               rem_ff  <= a_sz - req_ff;
               page_ff <= fb_ff;
            end
         end
         ST_AL_P2: begin
            mkr_ff     <= split_ff && (rem_ff > HDR_C);
            pgsize_ff  <= AW'(pg_c);
            r_ff       <= AW'(CW'(page_ff) + HDR_C + req_ff);
            rsz_ff     <= AW'(rem_ff - HDR_C);
            lk_addr_ff <= nxt_ff;
            lk_val_ff  <= (rem_ff > HDR_C) ? AW'(CW'(page_ff) + HDR_C + req_ff) : page_ff;
            lk_ret_ff  <= ST_AL_DONE;
            if (!split_ff) begin
               aw_ff.used <= 1'b1;
            end else if (!half_ff) begin
               aw_ff <= '{start: aw_ff.start, used: 1'b1, has_prev: aw_ff.has_prev,
                          size: AW'(pg_c), prev: aw_ff.prev};
            end
         end
         ST_AL_DONE: begin
            st_ff  <= STATUS_OK;
            res_ff <= CW'(page_ff) + HDR_C;
            if (op_ff == OP_RESIZE) mv_ff <= 1'b1;
         end
         ST_RC_INIT: begin
            w_ff    <= '0;
            best_ff <= '0;
         end
         ST_RC_CHK: begin
            if (!rd_word.used && (rd_word.size > best_ff)) best_ff <= rd_word.size;
            w_ff <= walk_next;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_status_ff <= st_ff;
               rsp_res_ff    <= res_ff[OFF_W-1:0];
               rsp_moved_ff  <= mv_ff;
               rsp_lf_ff     <= (CW'(best_ff) > LF_MAX) ? SIZE_W'(4095)
                                                        : SIZE_W'(CW'(best_ff));
            end
         end
         default: st_ff <= st_ff;
      endcase
   end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;
   import bta_pkg::*;

   localparam int HEAP        = HEAP_UNITS_DEF;
   localparam int HDR         = HEADER_UNITS_DEF;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int DRAIN_WAIT  = 400;
   localparam logic [OP_W-1:0] OP_BAD = 2'd3;

   typedef struct {
      logic              status;
      logic [OFF_W-1:0]  result_offset;
      logic              moved;
      logic [SIZE_W-1:0] largest_free;
   } heap_rsp_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   bta_req_if req_chan ();
   bta_rsp_if rsp_chan ();

   boundary_tag_heap_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Heap image kept by the testbench
   bit          tag_start [HEAP];
   bit          tag_used  [HEAP];
   bit          tag_hasp  [HEAP];
   int unsigned tag_size  [HEAP];
   int unsigned tag_prev  [HEAP];
   int unsigned largest_now;
   bit          upper_half;

   heap_rsp_t   pending_rsp[$];
   int unsigned live_blocks[$];
   int          error_count;
   int          cycle_count;
   int          burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned after_block(int unsigned h);
      return h + HDR + tag_size[h];
   endfunction

   function automatic void set_back(int unsigned h, int unsigned p);
      if (h < HEAP) begin
         tag_prev[h] = p;
         tag_hasp[h] = 1'b1;
      end
   endfunction

   function automatic void carve_block(int unsigned h, int unsigned sz, int unsigned p);
      if (h < HEAP) begin
         tag_start[h] = 1'b1;
         tag_used[h]  = 1'b0;
         tag_size[h]  = sz;
         tag_prev[h]  = p;
         tag_hasp[h]  = 1'b1;
      end
   endfunction

   function automatic void heap_init();
      for (int i = 0; i < HEAP; i++) begin
         tag_start[i] = 0; tag_used[i] = 0; tag_hasp[i] = 0;
         tag_size[i] = 0; tag_prev[i] = 0;
      end
      tag_start[0] = 1'b1;
      tag_size[0]  = HEAP - HDR;
      largest_now  = HEAP - HDR;
   endfunction

   function automatic void find_largest();
      int unsigned h, best, guard;
      h = 0; best = 0; guard = 0;
      while (h < HEAP && guard <= HEAP) begin
         if (!tag_used[h] && tag_size[h] > best) best = tag_size[h];
         h = after_block(h);
         guard++;
      end
      largest_now = best;
   endfunction

   // First fit with optional upper-half placement
   function automatic bit first_fit(int unsigned want, output int unsigned where);
      int unsigned h, guard, sz, nxt, pg, rem, lft, r;
      h = 0; guard = 0; where = 0;
      while (h < HEAP && guard <= HEAP) begin
         if (!tag_used[h] && tag_size[h] >= want) break;
         h = after_block(h);
         guard++;
      end
      if (h >= HEAP || guard > HEAP) return 1'b0;
      sz  = tag_size[h];
      nxt = h + HDR + sz;
      pg  = h;
      if (sz - want > HDR) begin
         if (upper_half && sz / 2 > HDR + want) begin
            lft = sz / 2;
            rem = sz - lft - (HDR + want);
            pg  = h + HDR + lft;
            tag_size[h] = lft;
            carve_block(pg, 0, h);
         end else begin
            rem = sz - want;
         end
         if (rem > HDR) begin
            r = pg + HDR + want;
            carve_block(r, rem - HDR, pg);
            set_back(nxt, r);
         end else begin
            want += rem;
            set_back(nxt, pg);
         end
         tag_size[pg] = want;
      end
      tag_used[pg] = 1'b1;
      where = pg;
      return 1'b1;
   endfunction

   // Release with merge on both sides
   function automatic void release_block(int unsigned h);
      int unsigned nxt, nn, p, nx;
      tag_used[h] = 1'b0;
      nxt = after_block(h);
      if (nxt < HEAP && !tag_used[nxt]) begin
         nn = after_block(nxt);
         tag_size[h] += HDR + tag_size[nxt];
         tag_start[nxt] = 1'b0;
         set_back(nn, h);
      end
      if (tag_hasp[h]) begin
         p = tag_prev[h];
         if (p < HEAP && !tag_used[p]) begin
            nx = after_block(h);
            tag_size[p] += HDR + tag_size[h];
            tag_start[h] = 1'b0;
            set_back(nx, p);
         end
      end
   endfunction

   function automatic bit names_live(int unsigned off, output int unsigned h);
      h = 0;
      if (off < HDR) return 1'b0;
      h = off - HDR;
      return h < HEAP && tag_start[h] && tag_used[h];
   endfunction

   function automatic heap_rsp_t predict_heap(logic [OP_W-1:0] op, int unsigned want,
                                              int unsigned off);
      heap_rsp_t   r;
      int unsigned h, w, sz, nxt, total, nn, tl;
      logic        ok;
      int unsigned res;
      logic        mv;
      ok = STATUS_FAIL; res = 0; mv = 1'b0;
      if (op == OP_ALLOC) begin
         if (first_fit(want, w)) begin
            ok = STATUS_OK; res = w + HDR;
         end
      end else if (op == OP_FREE) begin
         if (names_live(off, h)) begin
            release_block(h);
            ok = STATUS_OK;
         end
      end else if (op == OP_RESIZE) begin
         if (names_live(off, h)) begin
            sz  = tag_size[h];
            nxt = after_block(h);
            ok  = STATUS_OK;
            res = off;
            if (nxt < HEAP && !tag_used[nxt] && sz + HDR + tag_size[nxt] > want) begin
               total = sz + HDR + tag_size[nxt];
               nn = after_block(nxt);
               tl = h;
               tag_start[nxt] = 1'b0;
               if (total - want > HDR) begin
                  tl = h + HDR + want;
                  tag_size[h] = want;
                  carve_block(tl, total - want - HDR, h);
               end else begin
                  tag_size[h] = total;
               end
               set_back(nn, tl);
            end else if (want > sz) begin
               if (first_fit(want, w)) begin
                  release_block(h);
                  res = w + HDR;
                  mv  = 1'b1;
               end else begin
                  ok = STATUS_FAIL; res = 0;
               end
            end
         end
      end
      find_largest();
      r.status        = ok;
      r.result_offset = res[OFF_W-1:0];
      r.moved         = mv;
      r.largest_free  = (largest_now > 4095) ? 12'd4095 : largest_now[SIZE_W-1:0];
      return r;
   endfunction

   // Send one request in bursts; returns the predicted response
   task automatic send_request(input logic [OP_W-1:0] op, input int unsigned want,
                               input int unsigned off, output heap_rsp_t r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.op           <= op;
      req_chan.req_size     <= want[SIZE_W-1:0];
      req_chan.block_offset <= off[OFF_W-1:0];
      do @(posedge clock); while (!req_chan.ready);
      r = predict_heap(op, want, off);
      pending_rsp.push_back(r);
      // track live blocks for well-formed traffic
      if (r.status == STATUS_OK) begin
         if (op == OP_ALLOC) live_blocks.push_back(r.result_offset);
         else if (op == OP_FREE || (op == OP_RESIZE && r.moved)) begin
            foreach (live_blocks[i])
               if (live_blocks[i] == off) begin
                  live_blocks.delete(i);
                  break;
               end
            if (op == OP_RESIZE) live_blocks.push_back(r.result_offset);
         end
      end
      @(negedge clock);
   endtask

   task automatic go_quiet();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      wait (pending_rsp.size() == 0);
      @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_mode(input logic v);
      go_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      upper_half = v;
   endtask

   function automatic int unsigned pick_size();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 80) return $urandom_range(0, 40);
      if (k < 96) return $urandom_range(0, 400);
      return $urandom_range(0, 4095);
   endfunction

   // Response check
   always @(posedge clock) begin
      heap_rsp_t e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_chan.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.result_offset !== e.result_offset) begin
               $error("result_offset exp %0d got %0d", e.result_offset,
                      rsp_chan.result_offset);
               error_count++;
            end
            if (rsp_chan.moved !== e.moved) begin
               $error("moved exp %0d got %0d", e.moved, rsp_chan.moved);
               error_count++;
            end
            if (rsp_chan.largest_free !== e.largest_free) begin
               $error("largest_free exp %0d got %0d", e.largest_free,
                      rsp_chan.largest_free);
               error_count++;
            end
         end
      end
   end

   // Receiver stall pattern, with long stall-free stretches
   initial begin
      logic [15:0] stall_mask;
      int          span;
      rsp_chan.ready = 1'b0;
      forever begin
         stall_mask = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
         span = $urandom_range(16, 200);
         for (int i = 0; i < span; i++) begin
            @(negedge clock);
            rsp_chan.ready <= ~stall_mask[i % 16];
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_directed();
      heap_rsp_t r, a, b, c;
      send_request(OP_ALLOC, 0, 0, a);
      send_request(OP_ALLOC, 4095, 0, r);          // no fit
      send_request(OP_ALLOC, 10, 0, b);
      send_request(OP_ALLOC, 20, 0, c);
      send_request(OP_ALLOC, 30, 0, r);
      send_request(OP_FREE, 0, 0, r);               // offset below header
      send_request(OP_FREE, 0, 4095, r);            // not a block
      send_request(OP_BAD, 4095, 4095, r);          // unknown op
      send_request(OP_FREE, 0, b.result_offset, r);
      send_request(OP_RESIZE, 5, a.result_offset, r);   // grow into freed neighbor
      send_request(OP_RESIZE, 2, a.result_offset, r);   // shrink with free neighbor
      send_request(OP_FREE, 0, c.result_offset, r);
      send_request(OP_RESIZE, 0, r.result_offset, r);   // offset 0: bad
      send_request(OP_RESIZE, 4000, a.result_offset, r);
      send_request(OP_RESIZE, 4095, r.result_offset, r); // relocate fails
      while (live_blocks.size() > 0)
         send_request(OP_FREE, 0, live_blocks[0], r);
      send_request(OP_ALLOC, 4095 - HDR, 0, a);     // exact whole heap
      send_request(OP_RESIZE, 4094, a.result_offset, r); // shrink, no neighbor
      send_request(OP_FREE, 0, a.result_offset, r);
   endtask

   task automatic test_upper_half();
      heap_rsp_t r;
      send_request(OP_ALLOC, 7, 0, r);
      send_request(OP_ALLOC, 2000, 0, r);
      send_request(OP_ALLOC, 3, 0, r);
      while (live_blocks.size() > 0)
         send_request(OP_FREE, 0, live_blocks[live_blocks.size() - 1], r);
   endtask

   task automatic test_random(input int count);
      heap_rsp_t   r;
      int unsigned k, idx;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         if (live_blocks.size() == 0) k = 0;
         else if (live_blocks.size() > 40 && k < 45) k = 50;
         idx = (live_blocks.size() > 0) ? $urandom_range(0, live_blocks.size() - 1) : 0;
         if (k < 45)
            send_request(OP_ALLOC, pick_size(), $urandom_range(0, 4095), r);
         else if (k < 70)
            send_request(OP_FREE, $urandom_range(0, 4095), live_blocks[idx], r);
         else if (k < 90)
            send_request(OP_RESIZE, pick_size(), live_blocks[idx], r);
         else
            send_request(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), r);
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      burst_left  = 0;
      upper_half  = 1'b0;
      heap_init();
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_wdata = 1'b0;
      req_chan.valid        = 1'b0;
      req_chan.op           = OP_ALLOC;
      req_chan.req_size     = '0;
      req_chan.block_offset = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_mode(1'b0);
      test_directed();
      write_mode(1'b1);
      test_upper_half();
      test_directed();
      test_random(300);
      write_mode(1'b0);
      test_random(300);
      write_mode(1'b1);
      test_random(300);
      write_mode(1'b0);
      test_random(300);

      req_chan.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/bta_pkg.sv
hw/rtl/bta_req_if.sv
hw/rtl/bta_ram.sv
hw/rtl/boundary_tag_heap_allocator.sv
sim/testbench.sv
